// ----- sv/srs_pkg.sv -----
// Shared types and constants for the sorted rank set.
package srs_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int RANK_W  = 8;

    // Request kinds carried on the input tuser bit
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_FULL,
        STATUS_RANGE
    } status_t;

    // Row-wide control broadcast to every cell
    typedef struct packed {
        logic               capture;
        logic               ins;
        logic               rem;
        logic               desc;
        logic [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

// ----- sv/srs_cell.sv -----
// One storage cell of the sorted row: holds an entry and its compare flag.
module srs_cell
(
    input  logic                       clk,
    input  srs_pkg::cell_ctl_t         ctl,
    input  logic                       in_list,
    input  logic                       tail_sel,
    input  logic                       pre,
    input  logic [srs_pkg::VALUE_W-1:0] left_entry,
    input  logic [srs_pkg::VALUE_W-1:0] right_entry,
    output logic [srs_pkg::VALUE_W-1:0] entry,
    output logic                       flag
);

    logic [srs_pkg::VALUE_W-1:0] entry_reg;
    logic [srs_pkg::VALUE_W-1:0] entry_next;
    logic                        flag_reg;
    logic                        flag_next;
    logic                        ahead;

    // Stored entry stands strictly ahead of the incoming value
    assign ahead = ctl.desc ? (entry_reg > ctl.value) : (entry_reg < ctl.value);

    always_comb
    begin
        flag_next  = flag_reg;
        entry_next = entry_reg;
        if (ctl.capture)
        begin
            flag_next = in_list && ahead;
        end
        if (ctl.ins)
        begin
            // Keep when before the slot, take the value at the slot, shift down after it
            if (!pre)
            begin
                entry_next = left_entry;
            end
            else if (!flag_reg)
            begin
                entry_next = ctl.value;
            end
        end
        else if (ctl.rem && tail_sel)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg  <= flag_next;
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign flag  = flag_reg;

endmodule

// ----- sv/srs_prefix.sv -----
// Parallel prefix over the cell flags: marks the insert slot and encodes its index.
module srs_prefix #(
    parameter int CAPACITY = 256
)
(
    input  logic [CAPACITY-1:0]         flags,
    output logic [CAPACITY-1:0]         pre,
    output logic [$clog2(CAPACITY)-1:0] slot
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int LEVELS = $clog2(CAPACITY);

    logic [CAPACITY-1:0] lvl [0:LEVELS];
    logic [CAPACITY-1:0] hit;

    assign lvl[0] = flags;

    genvar gl, gi;
    generate
        for (gl = 0; gl < LEVELS; gl++)
        begin : g_lvl
            for (gi = 0; gi < CAPACITY; gi++)
            begin : g_bit
                if (gi >= (1 << gl))
                begin : g_and
                    assign lvl[gl+1][gi] = lvl[gl][gi] & lvl[gl][gi - (1 << gl)];
                end
                else
                begin : g_pass
                    assign lvl[gl+1][gi] = lvl[gl][gi];
                end
            end
        end
    endgenerate

    // pre[i]: every cell ahead of i holds an entry that stays ahead
    assign pre = {lvl[LEVELS][CAPACITY-2:0], 1'b1};
    assign hit = pre & ~flags;

    always_comb
    begin
        slot = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (hit[i])
            begin
                slot = slot | IDX_W'(i);
            end
        end
    end

endmodule

// ----- sv/sorted_rank_set.sv -----
// Top level of the sorted rank set: handshakes, control and the row of cells.
//
//  Channel | Direction | Handshake              | Payload
//  s_axis  | in        | s_axis_tvalid/tready   | tdata: item_value, position; tuser: req_type
//  m_axis  | out       | m_axis_tvalid/tready   | tdata: rank, status
//  cfg     | in        | cfg_valid/cfg_ready    | cfg_data: order_descending
//
// An item is handled in order: the accept edge registers every cell's compare flag,
// and the apply edge resolves the slot through the prefix network and shifts the row.
// The output register holds one result; the next item may be accepted meanwhile,
// and its apply cycle waits until that result is taken.
// Reset empties the list and selects descending order; cfg_ready is always high.
module sorted_rank_set #(
    parameter int CAPACITY = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] item_value, [39:32] position
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] rank, [9:8] status, [15:10] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > srs_pkg::POS_W) ? CNT_W : srs_pkg::POS_W;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           order_reg, order_next;
    logic                           req_type_reg, req_type_next;
    logic [srs_pkg::VALUE_W-1:0]    value_reg, value_next;
    logic [srs_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                           out_valid_reg, out_valid_next;
    logic [srs_pkg::RANK_W-1:0]     rank_reg, rank_next;
    srs_pkg::status_t               status_reg, status_next;

    logic                           in_fire;
    logic                           apply_go;
    logic                           full;
    logic                           pos_ok;
    logic                           ins_ok;
    logic                           rem_ok;
    logic [CNT_W-1:0]               pos_cell;
    srs_pkg::cell_ctl_t             ctl;

    logic [srs_pkg::VALUE_W-1:0]    entries [CAPACITY];
    logic [CAPACITY-1:0]            flags;
    logic [CAPACITY-1:0]            pre;
    logic [CAPACITY-1:0]            in_list;
    logic [CAPACITY-1:0]            tail_sel;
    logic [IDX_W-1:0]               slot;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign apply_go      = (state_reg == ST_APPLY) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = 1'b1;

    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign pos_ok   = (CMP_W'(pos_reg) < CMP_W'(count_reg));
    assign ins_ok   = (req_type_reg == srs_pkg::REQ_INSERT) && !full;
    assign rem_ok   = (req_type_reg == srs_pkg::REQ_REMOVE) && pos_ok;
    // Only meaningful when the position is inside the list, where it fits
    assign pos_cell = CNT_W'(pos_reg);

    always_comb
    begin
        ctl.capture = in_fire;
        ctl.ins     = apply_go && ins_ok;
        ctl.rem     = apply_go && rem_ok;
        ctl.desc    = order_reg;
        ctl.value   = (state_reg == ST_IDLE) ? s_axis_tdata[31:0] : value_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [srs_pkg::VALUE_W-1:0] left_entry;
            logic [srs_pkg::VALUE_W-1:0] right_entry;

            if (gi == 0)
            begin : g_head
                assign left_entry = '0;
            end
            else
            begin : g_left
                assign left_entry = entries[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_right
                assign right_entry = entries[gi+1];
            end

            assign in_list[gi]  = (CNT_W'(gi) < count_reg);
            assign tail_sel[gi] = (CNT_W'(gi) >= pos_cell);

            srs_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .in_list     (in_list[gi]),
                .tail_sel    (tail_sel[gi]),
                .pre         (pre[gi]),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entries[gi]),
                .flag        (flags[gi])
            );
        end
    endgenerate

    srs_prefix #(
        .CAPACITY (CAPACITY)
    ) u_prefix (
        .flags (flags),
        .pre   (pre),
        .slot  (slot)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        order_next     = order_reg;
        req_type_next  = req_type_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        rank_next      = rank_reg;
        status_next    = status_reg;

        if (cfg_valid && cfg_ready)
        begin
            order_next = cfg_data;
        end

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_type_next = s_axis_tuser;
                    value_next    = s_axis_tdata[31:0];
                    pos_next      = s_axis_tdata[39:32];
                    state_next    = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (apply_go)
                begin
                    out_valid_next = 1'b1;
                    rank_next      = '0;
                    status_next    = srs_pkg::STATUS_DONE;
                    if (req_type_reg == srs_pkg::REQ_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = srs_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            rank_next  = srs_pkg::RANK_W'(slot);
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (!pos_ok)
                    begin
                        status_next = srs_pkg::STATUS_RANGE;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            order_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            order_reg     <= order_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        value_reg    <= value_next;
        pos_reg      <= pos_next;
        rank_reg     <= rank_next;
        status_reg   <= status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, status_reg, rank_reg};

endmodule

// ----- sv/srs_checker.sv -----
// Port-level checker for the sorted rank set, bound to the top level.
module srs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Drop input readiness for the apply cycle after each accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted during apply cycle");

    // Status code is never the unused encoding
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:8] != 2'd3)
        else $error("invalid status code");

    // Flagged results carry rank zero and clean padding
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9:8] != 2'd0 |->
            m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[15:10] == 6'd0)
        else $error("flagged result has nonzero rank");

endmodule

bind sorted_rank_set srs_checker u_srs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
